// File: design/tdq_pkg.sv
package tdq_pkg;

    typedef enum logic [1:0] {
        MODE_PCM16 = 2'd0,
        MODE_PCM24 = 2'd1,
        MODE_FLOAT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_SAT  = 2'd2,
        KIND_NUM  = 2'd3
    } kind_t;

    localparam logic [31:0] RNG_SEED = 32'd123456789;

    localparam logic [7:0] EXP_SPECIAL = 8'hFF;

    // scaled shift = biased exponent - 150 + log2(scale) + 16
    localparam logic signed [9:0] SHIFT_OFS_16 = 10'sd119;
    localparam logic signed [9:0] SHIFT_OFS_24 = 10'sd111;
    // from this shift on a normal mantissa always saturates
    localparam logic signed [9:0] SAT_SHIFT_16 = 10'sd9;
    localparam logic signed [9:0] SAT_SHIFT_24 = 10'sd17;
    localparam logic [4:0]        RSHIFT_MAX   = 5'd24;

    localparam logic signed [25:0] PCM16_MAX = 26'sd32767;
    localparam logic signed [25:0] PCM16_MIN = -26'sd32768;
    localparam logic signed [25:0] PCM24_MAX = 26'sd8388607;
    localparam logic signed [25:0] PCM24_MIN = -26'sd8388608;

    localparam logic [2:0] BYTES_PCM16 = 3'd2;
    localparam logic [2:0] BYTES_PCM24 = 3'd3;
    localparam logic [2:0] BYTES_FLOAT = 3'd4;

    typedef struct packed {
        kind_t              kind;
        logic               wide;
        logic               neg;
        logic               left;
        logic [4:0]         amt;
        logic [23:0]        mant;
        logic signed [16:0] dith;
        logic [31:0]        raw;
    } item_t;

endpackage

// File: design/tdq_in_if.sv
interface tdq_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_bits;

    modport source (output valid, output sample_bits, input ready);
    modport sink   (input valid, input sample_bits, output ready);
endinterface

// File: design/tdq_out_if.sv
interface tdq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pcm_word;
    logic [2:0]  byte_count;

    modport source (output valid, output pcm_word, output byte_count, input ready);
    modport sink   (input valid, input pcm_word, input byte_count, output ready);
endinterface

// File: design/tdq_front.sv
module tdq_front
(
    input  logic               clk,
    input  logic               rst_n,
    tdq_in_if.sink             sample,
    input  tdq_pkg::mode_t     mode,
    input  logic               full,
    output logic               push,
    output tdq_pkg::item_t     item
);

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    logic [31:0]        rng_reg;
    logic [31:0]        rng_next;
    logic [31:0]        rng_a;
    logic [31:0]        rng_b;
    logic [17:0]        dith_sum;
    logic               dithered;
    logic               wide;
    logic [7:0]         ex;
    logic [22:0]        man;
    logic [7:0]         ex_eff;
    logic signed [9:0]  shift;
    logic signed [9:0]  rshift;
    logic signed [9:0]  sat_shift;

    assign sample.ready = !full;
    assign push         = sample.valid && !full;

    assign rng_a    = xorshift(rng_reg);
    assign rng_b    = xorshift(rng_a);
    assign dith_sum = {2'b00, rng_a[15:0]} + {2'b00, rng_b[15:0]} - 18'd65536;

    assign ex     = sample.sample_bits[30:23];
    assign man    = sample.sample_bits[22:0];
    assign ex_eff = (ex == 8'd0) ? 8'd1 : ex;

    always_comb
    begin
        unique case (mode)
            tdq_pkg::MODE_PCM16:
            begin
                dithered = 1'b1;
                wide     = 1'b0;
            end
            tdq_pkg::MODE_PCM24:
            begin
                dithered = 1'b1;
                wide     = 1'b1;
            end
            default:
            begin
                dithered = 1'b0;
                wide     = 1'b0;
            end
        endcase
    end

    assign sat_shift = wide ? tdq_pkg::SAT_SHIFT_24 : tdq_pkg::SAT_SHIFT_16;
    assign shift     = $signed({2'b00, ex_eff})
                       - (wide ? tdq_pkg::SHIFT_OFS_24 : tdq_pkg::SHIFT_OFS_16);
    assign rshift    = -shift;

    always_comb
    begin
        item.wide = wide;
        item.neg  = sample.sample_bits[31];
        item.mant = {(ex != 8'd0), man};
        item.dith = $signed(dith_sum[16:0]);
        item.raw  = sample.sample_bits;
        item.left = 1'b0;
        item.amt  = 5'd0;
        if (!dithered)
        begin
            item.kind = tdq_pkg::KIND_PASS;
        end
        else if (ex == tdq_pkg::EXP_SPECIAL)
        begin
            item.kind = (man != 23'd0) ? tdq_pkg::KIND_ZERO : tdq_pkg::KIND_SAT;
        end
        else if (shift >= sat_shift)
        begin
            item.kind = tdq_pkg::KIND_SAT;
        end
        else if (shift >= 10'sd0)
        begin
            item.kind = tdq_pkg::KIND_NUM;
            item.left = 1'b1;
            item.amt  = shift[4:0];
        end
        else
        begin
            item.kind = tdq_pkg::KIND_NUM;
            item.amt  = (rshift > $signed({5'd0, tdq_pkg::RSHIFT_MAX}))
                        ? tdq_pkg::RSHIFT_MAX : rshift[4:0];
        end
    end

    assign rng_next = (push && dithered) ? rng_b : rng_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg <= tdq_pkg::RNG_SEED;
        end
        else
        begin
            rng_reg <= rng_next;
        end
    end

endmodule

// File: design/tdq_queue.sv
module tdq_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tdq_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output tdq_pkg::item_t  head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    tdq_pkg::item_t  slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/tdq_back.sv
module tdq_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  tdq_pkg::item_t  head,
    output logic            pop,
    tdq_out_if.source       pcm
);

    typedef struct packed {
        tdq_pkg::kind_t kind;
        logic           wide;
        logic           neg;
        logic           st;
        logic [41:0]    tf;
        logic [31:0]    raw;
    } stage_t;

    logic               a_valid_reg;
    logic               a_valid_next;
    stage_t             a_reg;
    stage_t             a_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [31:0]        pcm_word_reg;
    logic [31:0]        pcm_word_next;
    logic [2:0]         byte_count_reg;
    logic [2:0]         byte_count_next;
    logic               advance;
    logic               take;
    logic [39:0]        q_left;
    logic [47:0]        q_right;
    logic [41:0]        qx;
    logic [41:0]        qs;
    logic               st;
    logic signed [25:0] fl;
    logic signed [25:0] r;
    logic signed [25:0] lo;
    logic signed [25:0] hi;
    logic signed [25:0] clamped;
    logic               inc;

    assign advance = !out_valid_reg || pcm.ready;
    assign take    = !a_valid_reg || advance;
    assign pop     = take && !empty;

    // stage one: align mantissa, apply sign, add dither
    assign q_left  = 40'(head.mant) << head.amt;
    assign q_right = {head.mant, 24'd0} >> head.amt;
    assign qx      = head.left ? {2'b00, q_left} : {18'd0, q_right[47:24]};
    assign st      = !head.left && (|q_right[23:0]);
    assign qs      = head.neg ? (~qx + {41'd0, ~st}) : qx;

    always_comb
    begin
        a_next.kind  = head.kind;
        a_next.wide  = head.wide;
        a_next.neg   = head.neg;
        a_next.st    = st;
        a_next.tf    = qs + {{25{head.dith[16]}}, head.dith};
        a_next.raw   = head.raw;
        a_valid_next = take ? !empty : a_valid_reg;
    end

    // stage two: truncate toward zero, saturate, pack
    assign fl  = $signed(a_reg.tf[41:16]);
    assign inc = a_reg.tf[41] && (a_reg.st || (|a_reg.tf[15:0]));
    assign r   = fl + $signed({25'd0, inc});
    assign lo  = a_reg.wide ? tdq_pkg::PCM24_MIN : tdq_pkg::PCM16_MIN;
    assign hi  = a_reg.wide ? tdq_pkg::PCM24_MAX : tdq_pkg::PCM16_MAX;

    always_comb
    begin
        clamped = r;
        case (a_reg.kind)
            tdq_pkg::KIND_SAT:  clamped = a_reg.neg ? lo : hi;
            tdq_pkg::KIND_ZERO: clamped = '0;
            default:
            begin
                if (r > hi)
                begin
                    clamped = hi;
                end
                else if (r < lo)
                begin
                    clamped = lo;
                end
            end
        endcase

        if (a_reg.kind == tdq_pkg::KIND_PASS)
        begin
            pcm_word_next   = a_reg.raw;
            byte_count_next = tdq_pkg::BYTES_FLOAT;
        end
        else if (a_reg.wide)
        begin
            pcm_word_next   = {8'd0, clamped[23:0]};
            byte_count_next = tdq_pkg::BYTES_PCM24;
        end
        else
        begin
            pcm_word_next   = {16'd0, clamped[15:0]};
            byte_count_next = tdq_pkg::BYTES_PCM16;
        end

        out_valid_next = advance ? a_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_reg <= a_next;
        end
        if (advance && a_valid_reg)
        begin
            pcm_word_reg   <= pcm_word_next;
            byte_count_reg <= byte_count_next;
        end
    end

    assign pcm.valid      = out_valid_reg;
    assign pcm.pcm_word   = pcm_word_reg;
    assign pcm.byte_count = byte_count_reg;

endmodule

// File: design/tpdf_dither_quantizer_top.sv
// A queued word passes through the stage-one register, then the output register.
// Throughput: one word per cycle while pcm.ready does not stall the two-stage back end.
// Under an output stall the queue takes QUEUE_DEPTH words and the back end two more,
// then input stalls.
// Reset: rst_n clears all control state, the mode to 16-bit PCM and the
// dither generator to its seed; queue and pipeline payload are not reset.
module tpdf_dither_quantizer_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tdq_in_if.sink      sample,
    tdq_out_if.source   pcm
);

    tdq_pkg::mode_t       mode_q;
    logic [1:0]           mode_bits_reg;
    logic [1:0]           mode_bits_next;
    logic                 wr_en;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;
    tdq_pkg::item_t       item;
    tdq_pkg::item_t       head;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign mode_bits_next = wr_en ? pwdata[1:0] : mode_bits_reg;
    assign mode_q   = tdq_pkg::mode_t'(mode_bits_reg);
    assign prdata   = (paddr[2] == 1'b0) ? {30'd0, mode_bits_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_bits_reg <= tdq_pkg::MODE_PCM16;
        end
        else
        begin
            mode_bits_reg <= mode_bits_next;
        end
    end

    tdq_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .mode   (mode_q),
        .full   (full),
        .push   (push),
        .item   (item)
    );

    tdq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    tdq_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .head  (head),
        .pop   (pop),
        .pcm   (pcm)
    );

endmodule
